// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bpa_pkg.sv -----
// Shared types, constants and helper functions of the buddy page allocator.
package bpa_pkg;

    localparam int PFN_BITS = 12;
    localparam int NPAGES   = 1 << PFN_BITS;
    localparam int NORDERS  = PFN_BITS;
    localparam int ORD_W    = 4;
    localparam int CNT_W    = PFN_BITS + 1;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef logic [PFN_BITS-1:0] pfn_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [ORD_W-1:0]    ord_t;

    typedef struct packed {
        logic free;
        logic head;
        ord_t ord;
    } page_t;

    localparam int PAGE_W = $bits(page_t);

    function automatic cnt_t pow2(ord_t o);
        return cnt_t'(1) << o;
    endfunction

    function automatic ord_t calc_top(cnt_t eff);
        ord_t t;
        t = '0;
        for (int o = 1; o < NORDERS; o++)
        begin
            if ((cnt_t'(1) << o) <= eff)
            begin
                t = ord_t'(o);
            end
        end
        return t;
    endfunction

endpackage

// ----- sv/bpa_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/buddy_page_allocator.sv -----
// Top level of the binary buddy page allocator with its sequencer.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------------
//   config   | psel/penable/pwrite     | paddr, pwdata, prdata (page_count)
//   request  | in_valid / in_ready     | mode, block_pfn, order, range_end
//   response | out_valid / out_ready   | status, result_pfn, free_page_count,
//            |                         | total_page_count, top_order
//
// After reset a clearing pass writes all 4096 page records.
// Each request is worked by one page pointer and counter under a sequencer, one
// page record access per cycle: a page check reads and then examines its record,
// a page mark writes one record, a list push runs S_PUSH, the marks, S_PUSH_FIN
// and S_PUSH_LINK, an unlink S_UNL and S_UNL_RD, and an order scan S_ALLOC_SCAN.
// The response waits in an output register until its transfer completes.
module buddy_page_allocator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           mode,
    input  bpa_pkg::pfn_t        block_pfn,
    input  bpa_pkg::ord_t        order,
    input  bpa_pkg::cnt_t        range_end,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output bpa_pkg::pfn_t        result_pfn,
    output bpa_pkg::cnt_t        free_page_count,
    output bpa_pkg::cnt_t        total_page_count,
    output bpa_pkg::ord_t        top_order
);

    import bpa_pkg::*;

    localparam logic REG_PAGE_COUNT = 1'b0;

    localparam logic [4:0] S_CLR         = 5'd0;
    localparam logic [4:0] S_IDLE        = 5'd1;
    localparam logic [4:0] S_CHK_RD      = 5'd2;
    localparam logic [4:0] S_CHK_EV      = 5'd3;
    localparam logic [4:0] S_ADD_ORD     = 5'd4;
    localparam logic [4:0] S_ADD_NEXT    = 5'd5;
    localparam logic [4:0] S_PUSH        = 5'd6;
    localparam logic [4:0] S_MARK        = 5'd7;
    localparam logic [4:0] S_PUSH_FIN    = 5'd8;
    localparam logic [4:0] S_PUSH_LINK   = 5'd9;
    localparam logic [4:0] S_UNL         = 5'd10;
    localparam logic [4:0] S_UNL_RD      = 5'd11;
    localparam logic [4:0] S_ALLOC_SCAN  = 5'd12;
    localparam logic [4:0] S_ALLOC_SPLIT = 5'd13;
    localparam logic [4:0] S_MERGE       = 5'd14;
    localparam logic [4:0] S_MERGE_EV    = 5'd15;
    localparam logic [4:0] S_MERGE_UP    = 5'd16;
    localparam logic [4:0] S_FREE_PUSH   = 5'd17;
    localparam logic [4:0] S_FREE_END    = 5'd18;
    localparam logic [4:0] S_FIN         = 5'd19;

    logic [4:0] state_reg, state_next;
    logic [4:0] mark_ret_reg, mark_ret_next;
    logic [4:0] call_ret_reg, call_ret_next;
    logic [1:0] mode_reg, mode_next;
    pfn_t       pfn_reg, pfn_next;
    ord_t       ord_reg, ord_next;
    ord_t       req_reg, req_next;
    cnt_t       end_reg, end_next;
    cnt_t       ptr_reg, ptr_next;
    pfn_t       cnt_reg, cnt_next;
    logic       mark_free_reg, mark_free_next;
    pfn_t       tgt_pfn_reg, tgt_pfn_next;
    ord_t       tgt_ord_reg, tgt_ord_next;
    logic [1:0] status_reg, status_next;
    pfn_t       res_pfn_reg, res_pfn_next;
    cnt_t       free_total_reg, free_total_next;
    cnt_t       added_total_reg, added_total_next;
    cnt_t       page_count_reg, page_count_next;
    cnt_t       list_first_reg [NORDERS];
    cnt_t       list_first_next [NORDERS];
    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_status_reg, out_status_next;
    pfn_t       out_pfn_reg, out_pfn_next;
    cnt_t       out_free_reg, out_free_next;
    cnt_t       out_total_reg, out_total_next;
    ord_t       out_top_reg, out_top_next;

    logic       pm_we;
    pfn_t       pm_waddr, pm_raddr;
    page_t      pm_wdata, pm_rdata;
    logic       nl_we, pl_we;
    pfn_t       nl_waddr, pl_waddr;
    cnt_t       nl_wdata, pl_wdata, nl_rdata, pl_rdata;

    cnt_t                 eff;
    ord_t                 top;
    cnt_t                 first;
    cnt_t                 lf_cur;
    pfn_t                 bud;
    logic                 accept;
    logic                 cfg_wr;
    logic [CNT_W:0]       fend;
    logic [CNT_W:0]       asum;
    cnt_t                 blk;
    cnt_t                 pnew;
    ord_t                 o1;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PAGE_COUNT);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PAGE_COUNT) ? 32'(page_count_reg) : 32'd0;

    assign eff    = (page_count_reg > cnt_t'(NPAGES)) ? cnt_t'(NPAGES) : page_count_reg;
    assign top    = calc_top(eff);
    assign first  = list_first_reg[tgt_ord_reg];
    assign lf_cur = list_first_reg[ord_reg];
    assign bud    = pfn_reg ^ pfn_t'(pow2(ord_reg));
    assign o1     = tgt_ord_reg + ord_t'(1);
    assign blk    = pow2(o1);
    assign pnew   = ptr_reg + pow2(tgt_ord_reg);
    assign fend   = (CNT_W+1)'(block_pfn) + (CNT_W+1)'(pow2(order));
    assign asum   = (CNT_W+1)'(added_total_reg) + (CNT_W+1)'(pow2(tgt_ord_reg));

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign pm_raddr = (state_reg == S_MERGE) ? bud : ptr_reg[PFN_BITS-1:0];

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign result_pfn       = out_pfn_reg;
    assign free_page_count  = out_free_reg;
    assign total_page_count = out_total_reg;
    assign top_order        = out_top_reg;

    always_comb
    begin
        state_next       = state_reg;
        mark_ret_next    = mark_ret_reg;
        call_ret_next    = call_ret_reg;
        mode_next        = mode_reg;
        pfn_next         = pfn_reg;
        ord_next         = ord_reg;
        req_next         = req_reg;
        end_next         = end_reg;
        ptr_next         = ptr_reg;
        cnt_next         = cnt_reg;
        mark_free_next   = mark_free_reg;
        tgt_pfn_next     = tgt_pfn_reg;
        tgt_ord_next     = tgt_ord_reg;
        status_next      = status_reg;
        res_pfn_next     = res_pfn_reg;
        free_total_next  = free_total_reg;
        added_total_next = added_total_reg;
        page_count_next  = cfg_wr ? pwdata[CNT_W-1:0] : page_count_reg;
        list_first_next  = list_first_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_pfn_next     = out_pfn_reg;
        out_free_next    = out_free_reg;
        out_total_next   = out_total_reg;
        out_top_next     = out_top_reg;
        pm_we            = 1'b0;
        pm_waddr         = tgt_pfn_reg;
        pm_wdata         = '0;
        nl_we            = 1'b0;
        nl_waddr         = tgt_pfn_reg;
        nl_wdata         = '0;
        pl_we            = 1'b0;
        pl_waddr         = tgt_pfn_reg;
        pl_wdata         = '0;

        unique case (state_reg)
            S_CLR:
            begin
                pm_we    = 1'b1;
                pm_waddr = cnt_reg;
                cnt_next = cnt_reg + pfn_t'(1);
                if (&cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next    = mode;
                    pfn_next     = block_pfn;
                    ord_next     = order;
                    req_next     = order;
                    status_next  = ST_OK;
                    res_pfn_next = '0;
                    unique case (mode)
                        MODE_ADD:
                        begin
                            if (cnt_t'(block_pfn) >= range_end)
                            begin
                                state_next = S_FIN;
                            end
                            else if (range_end > eff)
                            begin
                                status_next = ST_BAD;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                ptr_next   = cnt_t'(block_pfn);
                                end_next   = range_end;
                                state_next = S_CHK_RD;
                            end
                        end
                        MODE_ALLOC:
                        begin
                            if (order > top)
                            begin
                                status_next = ST_NONE;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                state_next = S_ALLOC_SCAN;
                            end
                        end
                        MODE_FREE:
                        begin
                            if ((order > top) ||
                                ((block_pfn & pfn_t'(pow2(order) - cnt_t'(1))) != '0) ||
                                (fend > (CNT_W+1)'(eff)))
                            begin
                                status_next = ST_BAD;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                ptr_next   = cnt_t'(block_pfn);
                                end_next   = fend[CNT_W-1:0];
                                state_next = S_CHK_RD;
                            end
                        end
                        default:
                        begin
                            status_next = ST_BAD;
                            state_next  = S_FIN;
                        end
                    endcase
                end
            end
            S_CHK_RD:
            begin
                state_next = S_CHK_EV;
            end
            S_CHK_EV:
            begin
                if (pm_rdata.free)
                begin
                    status_next = ST_BAD;
                    state_next  = S_FIN;
                end
                else if (ptr_reg + cnt_t'(1) == end_reg)
                begin
                    if (mode_reg == MODE_ADD)
                    begin
                        ptr_next     = cnt_t'(pfn_reg);
                        tgt_ord_next = '0;
                        state_next   = S_ADD_ORD;
                    end
                    else
                    begin
                        state_next = S_MERGE;
                    end
                end
                else
                begin
                    ptr_next   = ptr_reg + cnt_t'(1);
                    state_next = S_CHK_RD;
                end
            end
            S_ADD_ORD:
            begin
                if ((o1 <= top) && ((ptr_reg & (blk - cnt_t'(1))) == '0) &&
                    (blk <= end_reg - ptr_reg))
                begin
                    tgt_ord_next = o1;
                end
                else
                begin
                    tgt_pfn_next  = ptr_reg[PFN_BITS-1:0];
                    call_ret_next = S_ADD_NEXT;
                    state_next    = S_PUSH;
                end
            end
            S_ADD_NEXT:
            begin
                free_total_next  = free_total_reg + pow2(tgt_ord_reg);
                added_total_next = (asum > (CNT_W+1)'(NPAGES)) ? cnt_t'(NPAGES)
                                                               : asum[CNT_W-1:0];
                ptr_next = pnew;
                if (pnew < end_reg)
                begin
                    tgt_ord_next = '0;
                    state_next   = S_ADD_ORD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_PUSH:
            begin
                cnt_next       = '0;
                mark_free_next = 1'b1;
                mark_ret_next  = S_PUSH_FIN;
                state_next     = S_MARK;
            end
            S_MARK:
            begin
                pm_we         = 1'b1;
                pm_waddr      = tgt_pfn_reg + cnt_reg;
                pm_wdata.free = mark_free_reg;
                cnt_next      = cnt_reg + pfn_t'(1);
                if (cnt_reg == pfn_t'(pow2(tgt_ord_reg) - cnt_t'(1)))
                begin
                    state_next = mark_ret_reg;
                end
            end
            S_PUSH_FIN:
            begin
                pm_we         = 1'b1;
                pm_wdata.free = 1'b1;
                pm_wdata.head = 1'b1;
                pm_wdata.ord  = tgt_ord_reg;
                nl_we         = 1'b1;
                nl_wdata      = first;
                pl_we         = 1'b1;
                pl_wdata      = cnt_t'(NPAGES);
                state_next    = S_PUSH_LINK;
            end
            S_PUSH_LINK:
            begin
                if (!first[PFN_BITS])
                begin
                    pl_we    = 1'b1;
                    pl_waddr = first[PFN_BITS-1:0];
                    pl_wdata = cnt_t'(tgt_pfn_reg);
                end
                list_first_next[tgt_ord_reg] = cnt_t'(tgt_pfn_reg);
                state_next = call_ret_reg;
            end
            S_UNL:
            begin
                state_next = S_UNL_RD;
            end
            S_UNL_RD:
            begin
                if (!pl_rdata[PFN_BITS])
                begin
                    nl_we    = 1'b1;
                    nl_waddr = pl_rdata[PFN_BITS-1:0];
                    nl_wdata = nl_rdata;
                end
                else
                begin
                    list_first_next[tgt_ord_reg] = nl_rdata;
                end
                if (!nl_rdata[PFN_BITS])
                begin
                    pl_we    = 1'b1;
                    pl_waddr = nl_rdata[PFN_BITS-1:0];
                    pl_wdata = pl_rdata;
                end
                cnt_next       = '0;
                mark_free_next = 1'b0;
                mark_ret_next  = call_ret_reg;
                state_next     = S_MARK;
            end
            S_ALLOC_SCAN:
            begin
                if (!lf_cur[PFN_BITS])
                begin
                    tgt_pfn_next  = lf_cur[PFN_BITS-1:0];
                    tgt_ord_next  = ord_reg;
                    pfn_next      = lf_cur[PFN_BITS-1:0];
                    call_ret_next = S_ALLOC_SPLIT;
                    state_next    = S_UNL;
                end
                else if (ord_reg == top)
                begin
                    status_next = ST_NONE;
                    state_next  = S_FIN;
                end
                else
                begin
                    ord_next = ord_reg + ord_t'(1);
                end
            end
            S_ALLOC_SPLIT:
            begin
                if (ord_reg > req_reg)
                begin
                    ord_next      = ord_reg - ord_t'(1);
                    tgt_ord_next  = ord_reg - ord_t'(1);
                    tgt_pfn_next  = pfn_reg + pfn_t'(pow2(ord_reg - ord_t'(1)));
                    call_ret_next = S_ALLOC_SPLIT;
                    state_next    = S_PUSH;
                end
                else
                begin
                    free_total_next = (free_total_reg >= pow2(req_reg))
                                      ? free_total_reg - pow2(req_reg) : '0;
                    res_pfn_next    = pfn_reg;
                    state_next      = S_FIN;
                end
            end
            S_MERGE:
            begin
                if ((ord_reg < top) && (cnt_t'(bud) < eff))
                begin
                    state_next = S_MERGE_EV;
                end
                else
                begin
                    state_next = S_FREE_PUSH;
                end
            end
            S_MERGE_EV:
            begin
                if (pm_rdata.free && pm_rdata.head && (pm_rdata.ord == ord_reg))
                begin
                    tgt_pfn_next  = bud;
                    tgt_ord_next  = ord_reg;
                    call_ret_next = S_MERGE_UP;
                    state_next    = S_UNL;
                end
                else
                begin
                    state_next = S_FREE_PUSH;
                end
            end
            S_MERGE_UP:
            begin
                pfn_next   = pfn_reg & ~pfn_t'(pow2(ord_reg));
                ord_next   = ord_reg + ord_t'(1);
                state_next = S_MERGE;
            end
            S_FREE_PUSH:
            begin
                tgt_pfn_next  = pfn_reg;
                tgt_ord_next  = ord_reg;
                call_ret_next = S_FREE_END;
                state_next    = S_PUSH;
            end
            S_FREE_END:
            begin
                free_total_next = free_total_reg + pow2(req_reg);
                state_next      = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_pfn_next    = (status_reg == ST_OK) ? res_pfn_reg : '0;
                    out_free_next   = free_total_reg;
                    out_total_next  = added_total_reg;
                    out_top_next    = top;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            mark_ret_reg    <= S_IDLE;
            call_ret_reg    <= S_IDLE;
            mode_reg        <= MODE_ADD;
            pfn_reg         <= '0;
            ord_reg         <= '0;
            req_reg         <= '0;
            end_reg         <= '0;
            ptr_reg         <= '0;
            cnt_reg         <= '0;
            mark_free_reg   <= 1'b0;
            tgt_pfn_reg     <= '0;
            tgt_ord_reg     <= '0;
            status_reg      <= ST_OK;
            res_pfn_reg     <= '0;
            free_total_reg  <= '0;
            added_total_reg <= '0;
            page_count_reg  <= cnt_t'(NPAGES);
            for (int i = 0; i < NORDERS; i++)
            begin
                list_first_reg[i] <= cnt_t'(NPAGES);
            end
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_OK;
            out_pfn_reg     <= '0;
            out_free_reg    <= '0;
            out_total_reg   <= '0;
            out_top_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            mark_ret_reg    <= mark_ret_next;
            call_ret_reg    <= call_ret_next;
            mode_reg        <= mode_next;
            pfn_reg         <= pfn_next;
            ord_reg         <= ord_next;
            req_reg         <= req_next;
            end_reg         <= end_next;
            ptr_reg         <= ptr_next;
            cnt_reg         <= cnt_next;
            mark_free_reg   <= mark_free_next;
            tgt_pfn_reg     <= tgt_pfn_next;
            tgt_ord_reg     <= tgt_ord_next;
            status_reg      <= status_next;
            res_pfn_reg     <= res_pfn_next;
            free_total_reg  <= free_total_next;
            added_total_reg <= added_total_next;
            page_count_reg  <= page_count_next;
            list_first_reg  <= list_first_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_pfn_reg     <= out_pfn_next;
            out_free_reg    <= out_free_next;
            out_total_reg   <= out_total_next;
            out_top_reg     <= out_top_next;
        end
    end

    bpa_ram #(.WIDTH(PAGE_W), .DEPTH(NPAGES)) u_page_ram (
        .clk   (clk),
        .we    (pm_we),
        .waddr (pm_waddr),
        .wdata (pm_wdata),
        .raddr (pm_raddr),
        .rdata (pm_rdata)
    );

    bpa_ram #(.WIDTH(CNT_W), .DEPTH(NPAGES)) u_next_ram (
        .clk   (clk),
        .we    (nl_we),
        .waddr (nl_waddr),
        .wdata (nl_wdata),
        .raddr (tgt_pfn_reg),
        .rdata (nl_rdata)
    );

    bpa_ram #(.WIDTH(CNT_W), .DEPTH(NPAGES)) u_prev_ram (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .raddr (tgt_pfn_reg),
        .rdata (pl_rdata)
    );

endmodule

// ----- sv/bpa_checker.sv -----
// Port-level assertion checker for the buddy page allocator and its bind.
`include "assert_macros.svh"

module bpa_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [1:0]           status,
    input bpa_pkg::pfn_t        result_pfn,
    input bpa_pkg::cnt_t        free_page_count,
    input bpa_pkg::cnt_t        total_page_count
);

    import bpa_pkg::*;

    `BPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(result_pfn), "Stalled response changed.")
    `BPA_ASSERT_IMPL(a_pfn_zero, clk, rst_n, out_valid && (status != ST_OK),
        result_pfn == '0, "Failed request returned a page number.")
    `BPA_ASSERT_IMPL(a_count_bound, clk, rst_n, out_valid,
        (free_page_count <= cnt_t'(NPAGES)) && (total_page_count <= cnt_t'(NPAGES)),
        "Page count exceeds the managed range.")
    `BPA_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready,
        "Request accepted while the previous one is in progress.")

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);

// ----- verif/buddy_page_allocator_test.sv -----
// Self-checking testbench for the buddy page allocator: directed and random requests.
module buddy_page_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bpa_pkg::*;

    localparam logic [2:0] ADDR_PAGE_COUNT = 3'd0;
    localparam int CYCLE_LIMIT = 60000000;
    localparam int EMPTY = NPAGES;

    typedef struct {
        logic [1:0] status;
        pfn_t       pfn;
        cnt_t       free_cnt;
        cnt_t       total_cnt;
        ord_t       top;
    } answer_t;

    class allocator_scoreboard;
        bit   free_mark[NPAGES];
        bit   head_mark[NPAGES];
        ord_t blk_ord[NPAGES];
        cnt_t next_pg[NPAGES];
        cnt_t prev_pg[NPAGES];
        cnt_t list_head[NORDERS];
        int   free_tot;
        int   added_tot;
        int   page_limit;
        int   last_pfn;
        int   errors;
        int   held_pfn[$];
        int   held_ord[$];
        answer_t answers_q[$];

        function new();
            for (int i = 0; i < NPAGES; i++)
            begin
                free_mark[i] = 0;
                head_mark[i] = 0;
                blk_ord[i] = '0;
                next_pg[i] = '0;
                prev_pg[i] = '0;
            end
            for (int o = 0; o < NORDERS; o++)
            begin
                list_head[o] = cnt_t'(EMPTY);
            end
            free_tot = 0;
            added_tot = 0;
            page_limit = NPAGES;
            errors = 0;
            last_pfn = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function int usable_pages();
            return page_limit > NPAGES ? NPAGES : page_limit;
        endfunction

        function int top_ord();
            int o;
            o = 0;
            while (o + 1 < NORDERS && (1 << (o + 1)) <= usable_pages())
            begin
                o++;
            end
            return o;
        endfunction

        function void mark_pages(int pfn, int ord, bit is_free);
            int p;
            for (int i = 0; i < (1 << ord); i++)
            begin
                p = (pfn + i) % NPAGES;
                free_mark[p] = is_free;
                head_mark[p] = 0;
            end
        endfunction

        function void push_blk(int ord, int pfn);
            int first;
            first = list_head[ord];
            mark_pages(pfn, ord, 1);
            head_mark[pfn] = 1;
            blk_ord[pfn] = ord_t'(ord);
            next_pg[pfn] = cnt_t'(first);
            prev_pg[pfn] = cnt_t'(EMPTY);
            if (first < NPAGES)
            begin
                prev_pg[first] = cnt_t'(pfn);
            end
            list_head[ord] = cnt_t'(pfn);
        endfunction

        function void unlink_blk(int ord, int pfn);
            int pr;
            int nx;
            pr = prev_pg[pfn];
            nx = next_pg[pfn];
            if (pr < NPAGES)
            begin
                next_pg[pr] = cnt_t'(nx);
            end
            else
            begin
                list_head[ord] = cnt_t'(nx);
            end
            if (nx < NPAGES)
            begin
                prev_pg[nx] = cnt_t'(pr);
            end
            mark_pages(pfn, ord, 0);
            next_pg[pfn] = cnt_t'(EMPTY);
            prev_pg[pfn] = cnt_t'(EMPTY);
            blk_ord[pfn] = '0;
        endfunction

        function logic [1:0] carve_range(int start, int stop);
            int top;
            int p;
            int o;
            top = top_ord();
            if (stop > usable_pages())
            begin
                return ST_BAD;
            end
            for (p = start; p < stop; p++)
            begin
                if (free_mark[p])
                begin
                    return ST_BAD;
                end
            end
            p = start;
            while (p < stop)
            begin
                o = 0;
                while (o + 1 <= top && (p % (1 << (o + 1))) == 0 && (1 << (o + 1)) <= stop - p)
                begin
                    o++;
                end
                push_blk(o, p);
                free_tot += 1 << o;
                added_tot += 1 << o;
                if (added_tot > NPAGES)
                begin
                    added_tot = NPAGES;
                end
                p += 1 << o;
            end
            return ST_OK;
        endfunction

        function logic [1:0] take_block(int ord, output int pfn);
            int top;
            int cur;
            top = top_ord();
            pfn = 0;
            if (ord > top)
            begin
                return ST_NONE;
            end
            cur = ord;
            while (cur <= top && list_head[cur] >= NPAGES)
            begin
                cur++;
            end
            if (cur > top)
            begin
                return ST_NONE;
            end
            pfn = list_head[cur];
            unlink_blk(cur, pfn);
            while (cur > ord)
            begin
                cur--;
                push_blk(cur, (pfn + (1 << cur)) % NPAGES);
            end
            free_tot = free_tot >= (1 << ord) ? free_tot - (1 << ord) : 0;
            return ST_OK;
        endfunction

        function logic [1:0] return_block(int pfn, int ord);
            int top;
            int lim;
            int req;
            int bud;
            top = top_ord();
            lim = usable_pages();
            req = ord;
            if (ord > top || (pfn % (1 << ord)) != 0 || pfn + (1 << ord) > lim)
            begin
                return ST_BAD;
            end
            for (int i = 0; i < (1 << ord); i++)
            begin
                if (free_mark[pfn + i])
                begin
                    return ST_BAD;
                end
            end
            while (ord < top)
            begin
                bud = pfn ^ (1 << ord);
                if (bud >= lim || !free_mark[bud] || !head_mark[bud] || blk_ord[bud] != ord)
                begin
                    break;
                end
                unlink_blk(ord, bud);
                if (bud < pfn)
                begin
                    pfn = bud;
                end
                ord++;
            end
            push_blk(ord, pfn);
            free_tot += 1 << req;
            return ST_OK;
        endfunction

        function void note_request(logic [1:0] md, pfn_t bp, ord_t od, cnt_t re);
            answer_t a;
            int rp;
            rp = 0;
            if (md == MODE_ADD)
            begin
                a.status = (int'(bp) < int'(re)) ? carve_range(bp, re) : ST_OK;
            end
            else if (md == MODE_ALLOC)
            begin
                a.status = take_block(od, rp);
                if (a.status == ST_OK)
                begin
                    held_pfn.push_back(rp);
                    held_ord.push_back(od);
                end
            end
            else if (md == MODE_FREE)
            begin
                a.status = return_block(bp, od);
            end
            else
            begin
                a.status = ST_BAD;
            end
            if (a.status != ST_OK)
            begin
                rp = 0;
            end
            last_pfn = rp;
            a.pfn = pfn_t'(rp);
            a.free_cnt = cnt_t'(free_tot);
            a.total_cnt = cnt_t'(added_tot);
            a.top = ord_t'(top_ord());
            answers_q.push_back(a);
        endfunction

        task check_response(answer_t got);
            answer_t e;
            if (answers_q.size() == 0)
            begin
                report("response transfer with nothing expected");
                return;
            end
            e = answers_q.pop_front();
            if (got.status !== e.status)
                report($sformatf("status %0d, expected %0d", got.status, e.status));
            if (got.pfn !== e.pfn)
                report($sformatf("result_pfn %0d, expected %0d", got.pfn, e.pfn));
            if (got.free_cnt !== e.free_cnt)
                report($sformatf("free_page_count %0d, expected %0d", got.free_cnt, e.free_cnt));
            if (got.total_cnt !== e.total_cnt)
                report($sformatf("total_page_count %0d, expected %0d",
                    got.total_cnt, e.total_cnt));
            if (got.top !== e.top)
                report($sformatf("top_order %0d, expected %0d", got.top, e.top));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    pfn_t        block_pfn;
    ord_t        order;
    cnt_t        range_end;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    pfn_t        result_pfn;
    cnt_t        free_page_count;
    cnt_t        total_page_count;
    ord_t        top_order;

    allocator_scoreboard sb;
    bit calm;
    int out_wait;
    int cycles;

    buddy_page_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .block_pfn(block_pfn), .order(order), .range_end(range_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .result_pfn(result_pfn), .free_page_count(free_page_count),
        .total_page_count(total_page_count), .top_order(top_order)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_response('{status, result_pfn, free_page_count,
                    total_page_count, top_order});
                out_wait = calm ? 0 : $urandom_range(0, 7);
                out_ready <= (out_wait == 0);
            end
            else if (out_wait != 0)
            begin
                out_wait = out_wait - 1;
                out_ready <= (out_wait == 0);
            end
        end
    end

    task automatic send_request(logic [1:0] md, int bp, int od, int re);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= md;
        block_pfn <= pfn_t'(bp);
        order <= ord_t'(od);
        range_end <= cnt_t'(re);
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_request(md, pfn_t'(bp), ord_t'(od), cnt_t'(re));
    endtask

    task automatic drain_responses();
        in_valid <= 1'b0;
        while (sb.answers_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_page_count(int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_PAGE_COUNT;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.page_limit = value & 13'h1fff;
        @(posedge clk);
    endtask

    task automatic random_request();
        int r;
        int lim;
        int top;
        int start;
        int k;
        lim = sb.usable_pages();
        top = sb.top_ord();
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            start = $urandom_range(0, lim - 1);
            send_request(MODE_ADD, start, $urandom_range(0, 15),
                (start + $urandom_range(1, 16) > lim) ? lim : start + $urandom_range(1, 16));
        end
        else if (r < 85 && r >= 55 && sb.held_pfn.size() != 0)
        begin
            k = $urandom_range(0, sb.held_pfn.size() - 1);
            start = sb.held_pfn[k];
            r = sb.held_ord[k];
            sb.held_pfn.delete(k);
            sb.held_ord.delete(k);
            send_request(MODE_FREE, start, r, $urandom & 16'h1fff);
        end
        else if (r < 85)
        begin
            send_request(MODE_ALLOC, $urandom & 12'hfff,
                ($urandom_range(0, 9) == 0) ? top : $urandom_range(0, (top < 3) ? top : 3),
                $urandom & 16'h1fff);
        end
        else
        begin
            send_request(2'($urandom_range(0, 3)), $urandom & 12'hfff, $urandom & 4'hf,
                $urandom & 16'h1fff);
        end
    endtask

    initial
    begin
        int phase_pages[10];
        int blk;
        phase_pages = '{1, 8, 37, 64, 200, 4096, 5, 512, 4096, 4000};
        sb = new();
        clk = 1'b0;
        cycles = 0;
        calm = 0;
        out_wait = 0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        mode <= '0;
        block_pfn <= '0;
        order <= '0;
        range_end <= '0;
        out_ready <= 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_page_count(NPAGES);

        send_request(MODE_ALLOC, 0, 0, 0);
        send_request(2'd3, 12'hfff, 4'hf, 13'h1fff);
        send_request(MODE_ADD, 10, 0, 5);
        send_request(MODE_ADD, 0, 0, NPAGES + 1);
        send_request(MODE_ADD, 0, 0, 100);
        send_request(MODE_ADD, 50, 0, 60);
        send_request(MODE_ADD, 100, 0, NPAGES);
        send_request(MODE_ALLOC, 0, 11, 0);
        blk = sb.last_pfn;
        send_request(MODE_ALLOC, 0, 12, 0);
        send_request(MODE_ALLOC, 0, 15, 0);
        send_request(MODE_ALLOC, 0, 0, 0);
        send_request(MODE_FREE, sb.last_pfn, 0, 0);
        send_request(MODE_FREE, 1, 1, 0);
        send_request(MODE_FREE, 0, 12, 0);
        send_request(MODE_FREE, 0, 0, 0);
        send_request(MODE_ADD, blk, 0, blk + 2048);
        send_request(MODE_FREE, blk, 11, 0);
        send_request(MODE_ALLOC, 0, 11, 0);
        send_request(MODE_FREE, sb.last_pfn, 11, 0);
        send_request(MODE_ADD, NPAGES - 1, 0, NPAGES);
        sb.held_pfn.delete();
        sb.held_ord.delete();

        for (int ph = 0; ph < 10; ph++)
        begin
            drain_responses();
            write_page_count(phase_pages[ph]);
            calm = (ph % 3 == 0);
            if (phase_pages[ph] == 37)
            begin
                send_request(MODE_FREE, 32, 3, 0);
            end
            for (int n = 0; n < 125; n++)
            begin
                random_request();
            end
        end

        drain_responses();
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
